// ----- src/mso_pkg.sv -----
`timescale 1ns / 1ps

package mso_pkg;

  // Default sizes of the oscillator.
  localparam int unsigned STACK_DEPTH_C     = 16;
  localparam int unsigned PHASE_FRAC_BITS_C = 24;
  localparam int unsigned EXP_TABLE_SIZE_C  = 256;

  // Phase step width and its reset value (pitch zero at the default sample rate).
  localparam int unsigned   STEP_W          = 25;
  localparam logic [24:0]   BASE_STEP_RST_C = 25'd5592;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // One octave in 1/4096 semitone units.
  localparam logic [19:0] OCT_UNITS_C = 20'd49152;

  // Width of a table entry: 2^(i/N) in Q1.16 stays below 2^17.
  localparam int unsigned ENTRY_W = 17;

  // ln 2 in Q32 for the table series.
  localparam logic [63:0] LN2_Q32_C = 64'd2977044472;

  // Reciprocals: floor(x/3) = (x*21846) >> 16 for x < 32768, and
  // floor(2^30/127) as a first guess of a division by 127.
  localparam logic [14:0] RECIP3_C   = 15'd21846;
  localparam logic [23:0] RECIP127_C = 24'd8454660;

  // Offset that makes the scaled sample numerator non-negative (127 * 2^15).
  localparam logic signed [23:0] SAMP_OFFS_C = 24'sd4161536;

  // Request kinds on the input stream, carried in tuser.
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_NOTE_ON  = 2'd1,
    FUNC_NOTE_OFF = 2'd2,
    FUNC_WHEEL    = 2'd3
  } func_e;

  // What a request does once it reaches the end of the pitch pipeline.
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_STEP = 2'd1,
    KIND_ZERO = 2'd2
  } kind_e;

  // Exponent table entry round(2^(i/N) * 2^16) from x = floor(i * 2^32 / N),
  // evaluated as a power series of ln 2 * x in Q32.
  function automatic logic [ENTRY_W-1:0] exp_entry_f(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    y    = (x * LN2_Q32_C) >> 32;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      sum  = sum + term;
    end
    return ENTRY_W'((sum + 64'd32768) >> 16);
  endfunction

endpackage

// ----- src/mono_sawtooth_note_stack_osc_core.sv -----
// Monophonic sawtooth oscillator with last-note priority. Requests arrive on the
// slave stream with the request kind in tuser (sample tick, note on, note off,
// pitch wheel); only a sample tick produces a result on the master stream. The
// block takes one request per clock, and tready drops only when the master side
// stalls long enough to fill the pipeline. Note, wheel and tick requests travel
// in order through one 6-stage pitch pipeline (octave split, table index,
// exponent table, base step multiply, shift and saturate), so a tick always sees
// the step set by every earlier note or wheel request; the sample scaling then
// takes two more stages. The note stack lives in a one-port-write, one-port-read
// RAM with the top entry held in a register; its read port always fetches the
// entry below the top, so a note off finds the new top without waiting. The
// stack is not cleared after reset and the block is ready in the first cycle.
// base_step may be written through cfg_we_i only while no request is in flight.
`timescale 1ns / 1ps

module mono_sawtooth_note_stack_osc_core
  import mso_pkg::*;
#(
  parameter int unsigned STACK_DEPTH     = STACK_DEPTH_C,
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_C,
  parameter int unsigned EXP_TABLE_SIZE  = EXP_TABLE_SIZE_C
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // base_step register write
  input  logic                  cfg_we_i,
  input  logic [STEP_W-1:0]     cfg_wdata_i,
  // Request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // note[6:0], velocity[13:7], wheel[27:14]
  input  logic [1:0]            s_axis_tuser_i,   // func[1:0]
  // Sample stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o    // sample[15:0]
);

  localparam int unsigned CntW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned IdxW     = $clog2(EXP_TABLE_SIZE);
  localparam int unsigned RemW     = 16;
  localparam int unsigned TabProdW = RemW + $clog2(EXP_TABLE_SIZE + 1);
  localparam int unsigned XW       = $clog2(3 * EXP_TABLE_SIZE);
  localparam int unsigned IdxProdW = XW + 15;
  localparam int unsigned PhaseW   = PHASE_FRAC_BITS + 1;
  localparam int unsigned SumW     = ((PhaseW > STEP_W) ? PhaseW : STEP_W) + 1;
  localparam int unsigned SW       = PHASE_FRAC_BITS + 2;
  localparam int unsigned MW       = PHASE_FRAC_BITS + 12;
  localparam int unsigned ShR      = (PHASE_FRAC_BITS >= 15) ? PHASE_FRAC_BITS - 15 : 0;
  localparam int unsigned ShL      = (PHASE_FRAC_BITS < 15) ? 15 - PHASE_FRAC_BITS : 0;
  localparam int unsigned BaseProdW = STEP_W + ENTRY_W;
  localparam int unsigned ShiftW   = BaseProdW + 11;
  localparam int unsigned RawW     = ShiftW - 17;
  localparam int unsigned DivProdW = 47;

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  func_e              func;
  logic [6:0]         note;
  logic [6:0]         velocity;
  logic signed [13:0] wheel;

  assign func     = func_e'(s_axis_tuser_i);
  assign note     = s_axis_tdata_i[6:0];
  assign velocity = s_axis_tdata_i[13:7];
  assign wheel    = signed'(s_axis_tdata_i[27:14]);

  // ---------------------------------------------------------------------------
  // Exponent table: one octave, built at elaboration.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] exp_tab [EXP_TABLE_SIZE];

  for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_tab
    localparam logic [63:0] TabX = (64'(g) << 32) / 64'(EXP_TABLE_SIZE);
    assign exp_tab[g] = exp_entry_f(TabX);
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its content moves.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic en_out, en1, en2, en3, en4, en5, en6, en7, en8;
  logic in_acc;

  assign en_out = !out_valid_q || m_axis_tready_i;
  assign en8    = !v8_q || en_out;
  assign en7    = !v7_q || en8;
  assign en6    = !v6_q || en7;
  assign en5    = !v5_q || en6;
  assign en4    = !v4_q || en5;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign s_axis_tready_o = en1;
  assign in_acc          = s_axis_tvalid_i && en1;

  // ---------------------------------------------------------------------------
  // Note stack and front state
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [6:0]         top_q, top_d;
  logic signed [13:0] bend_q, bend_d;
  logic [6:0]         gain_q, gain_d;
  logic [STEP_W-1:0]  base_step_q;
  logic               full;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [AddrW-1:0]   ram_raddr;
  logic [6:0]         below;
  logic [6:0]         pitch_top;
  logic               v1_d;
  kind_e              k1_d;
  logic [19:0]        q1_d;

  assign full      = (cnt_q == CntW'(STACK_DEPTH));
  assign ram_waddr = full ? AddrW'(STACK_DEPTH - 1) : AddrW'(cnt_q);
  // The read port always fetches the entry just below the next top. A push
  // writes at or above the new top, so a write never hits the entry read in
  // the same cycle and no forwarding is needed.
  assign ram_raddr = AddrW'(cnt_d - CntW'(2));

  mso_ram #(
    .WIDTH (7),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (note),
    .raddr_i (ram_raddr),
    .rdata_o (below)
  );

  // Stack, bend and gain updates at acceptance; pick the pitch to evaluate.
  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    bend_d    = bend_q;
    gain_d    = gain_q;
    ram_we    = 1'b0;
    pitch_top = top_q;
    v1_d      = 1'b0;
    k1_d      = KIND_TICK;
    if (in_acc) begin
      unique case (func)
        FUNC_TICK: begin
          v1_d = 1'b1;
        end
        FUNC_NOTE_ON: begin
          ram_we    = 1'b1;
          top_d     = note;
          pitch_top = note;
          gain_d    = velocity;
          if (!full) begin
            cnt_d = cnt_q + CntW'(1);
          end
          v1_d = 1'b1;
          k1_d = KIND_STEP;
        end
        FUNC_NOTE_OFF: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CntW'(1);
            v1_d  = 1'b1;
            if (cnt_q == CntW'(1)) begin
              k1_d = KIND_ZERO;
            end else begin
              k1_d      = KIND_STEP;
              top_d     = below;
              pitch_top = below;
            end
          end
        end
        FUNC_WHEEL: begin
          bend_d = wheel;
          if (cnt_q != '0) begin
            v1_d = 1'b1;
            k1_d = KIND_STEP;
          end
        end
      endcase
    end
  end

  // Pitch in 1/4096 semitone plus one octave, always positive.
  assign q1_d = {1'b0, pitch_top, 12'd0} + {{6{bend_d[13]}}, bend_d} + OCT_UNITS_C;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bend_q      <= '0;
      gain_q      <= '0;
      base_step_q <= BASE_STEP_RST_C;
    end else begin
      cnt_q  <= cnt_d;
      bend_q <= bend_d;
      gain_q <= gain_d;
      if (cfg_we_i) begin
        base_step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // ---------------------------------------------------------------------------
  // Pitch pipeline payload
  // ---------------------------------------------------------------------------
  kind_e               k1_q, k2_q, k3_q, k4_q, k5_q, k6_q;
  logic [6:0]          g1_q, g2_q, g3_q, g4_q, g5_q, g6_q;
  logic [19:0]         q1_q;
  logic [3:0]          oct2_d, oct2_q, oct3_q, oct4_q, oct5_q, oct6_q;
  logic [RemW-1:0]     r2_d, r2_q;
  logic [XW-1:0]       x3_d, x3_q;
  logic [IdxW-1:0]     idx4_d, idx4_q;
  logic [ENTRY_W-1:0]  ent5_q;
  logic [BaseProdW-1:0] prod6_d, prod6_q;
  logic [20:0]         oct_prod;
  logic [5:0]          oct3x;
  logic [TabProdW-1:0] tab_prod;
  logic [IdxProdW-1:0] idx_prod;

  // Octave = floor(q / 49152) = floor((q >> 14) / 3); remainder inside the octave.
  assign oct_prod = 21'(q1_q[19:14]) * 21'(RECIP3_C);
  assign oct2_d   = oct_prod[19:16];
  assign oct3x    = 6'({oct2_d, 1'b0}) + 6'(oct2_d);
  assign r2_d     = RemW'(q1_q - {oct3x, 14'd0});

  // Table index = floor(r * N / 49152), done as >> 14 and then a divide by 3.
  assign tab_prod = TabProdW'(r2_q) * TabProdW'(EXP_TABLE_SIZE);
  assign x3_d     = XW'(tab_prod >> 14);
  assign idx_prod = IdxProdW'(x3_q) * IdxProdW'(RECIP3_C);
  assign idx4_d   = idx_prod[16 +: IdxW];

  assign prod6_d  = BaseProdW'(base_step_q) * BaseProdW'(ent5_q);

  always_ff @(posedge clk_i) begin
    if (en1) begin
      k1_q <= k1_d;
      g1_q <= gain_q;
      q1_q <= q1_d;
    end
    if (en2) begin
      k2_q   <= k1_q;
      g2_q   <= g1_q;
      oct2_q <= oct2_d;
      r2_q   <= r2_d;
    end
    if (en3) begin
      k3_q   <= k2_q;
      g3_q   <= g2_q;
      oct3_q <= oct2_q;
      x3_q   <= x3_d;
    end
    if (en4) begin
      k4_q   <= k3_q;
      g4_q   <= g3_q;
      oct4_q <= oct3_q;
      idx4_q <= idx4_d;
    end
    if (en5) begin
      k5_q   <= k4_q;
      g5_q   <= g4_q;
      oct5_q <= oct4_q;
      ent5_q <= exp_tab[idx4_q];
    end
    if (en6) begin
      k6_q    <= k5_q;
      g6_q    <= g5_q;
      oct6_q  <= oct5_q;
      prod6_q <= prod6_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Apply stage: phase step update, and phase advance for ticks.
  // ---------------------------------------------------------------------------
  logic [PhaseW-1:0]     phase_q, phase_d;
  logic [STEP_W-1:0]     phase_step_q, phase_step_d;
  logic                  app_fire;
  logic [ShiftW-1:0]     step_shift;
  logic [RawW-1:0]       step_raw;
  logic [STEP_W-1:0]     step_sat;
  logic [SumW-1:0]       phase_sum;
  logic signed [SW-1:0]  saw;
  logic signed [MW-1:0]  saw_ext, gain_ext, m7_d, m7_q;
  logic                  v7_d;

  assign app_fire   = v6_q && en7;
  assign step_shift = ShiftW'(prod6_q) << oct6_q;
  assign step_raw   = step_shift[ShiftW-1:17];
  assign step_sat   = (step_raw[RawW-1:STEP_W] != '0) ? '1 : step_raw[STEP_W-1:0];
  assign phase_sum  = SumW'(phase_q) + SumW'(phase_step_q);

  // Sawtooth value 2*frac(phase) - 1 times the gain.
  assign saw      = signed'(SW'({phase_q[PHASE_FRAC_BITS-1:0], 1'b0}) -
                            (SW'(1) << PHASE_FRAC_BITS));
  assign saw_ext  = MW'(saw);
  assign gain_ext = MW'(signed'({1'b0, g6_q}));
  assign m7_d     = saw_ext * gain_ext;
  assign v7_d     = v6_q && (k6_q == KIND_TICK);

  always_comb begin
    phase_d      = phase_q;
    phase_step_d = phase_step_q;
    if (app_fire) begin
      unique case (k6_q)
        KIND_TICK: begin
          phase_d = (phase_sum > (SumW'(1) << PHASE_FRAC_BITS)) ? '0 : PhaseW'(phase_sum);
        end
        KIND_STEP: phase_step_d = step_sat;
        KIND_ZERO: phase_step_d = '0;
        default:   phase_step_d = phase_step_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= '0;
      phase_step_q <= '0;
    end else begin
      phase_q      <= phase_d;
      phase_step_q <= phase_step_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample scaling: floor(m * 2^15 / (127 * 2^F)), divide by 127 through a
  // reciprocal guess and one correction step.
  // ---------------------------------------------------------------------------
  logic signed [23:0]    m_scaled;
  logic signed [23:0]    u_sum;
  logic [22:0]           u8_d, u8_q;
  logic [DivProdW-1:0]   prod8_d, prod8_q;
  logic [15:0]           quo0;
  logic [23:0]           rem;
  logic [15:0]           quo;
  logic [OUT_DATA_W-1:0] sample_q;

  assign m_scaled = 24'((m7_q <<< ShL) >>> ShR);
  assign u_sum    = m_scaled + SAMP_OFFS_C;
  assign u8_d     = 23'(u_sum);
  assign prod8_d  = DivProdW'(u8_d) * DivProdW'(RECIP127_C);

  assign quo0 = prod8_q[45:30];
  assign rem  = 24'(u8_q) - 24'({quo0, 7'd0}) + 24'(quo0);
  assign quo  = (rem >= 24'd127) ? quo0 + 16'd1 : quo0;

  always_ff @(posedge clk_i) begin
    if (en7) begin
      m7_q <= m7_d;
    end
    if (en8) begin
      u8_q    <= u8_d;
      prod8_q <= prod8_d;
    end
    if (en_out && v8_q) begin
      // Offset removal: quotient minus 2^15 flips the top bit.
      sample_q <= {~quo[15], quo[14:0]};
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      v8_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) v1_q <= v1_d;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v7_d;
      if (en8) v8_q <= v7_q;
      if (en_out) out_valid_q <= v8_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = sample_q;

endmodule

// ----- src/mso_ram.sv -----
`timescale 1ns / 1ps

module mso_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mso_checker.sv -----
`timescale 1ns / 1ps

module mso_checker
  import mso_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [1:0]            s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // Ticks held inside the block: eight pipeline stages and the output register.
  localparam logic [4:0] MaxInFlight = 5'd9;

  logic       tick_in;
  logic       sample_out;
  logic [4:0] pend_q;

  assign tick_in    = s_axis_tvalid_i && s_axis_tready_o &&
                      (s_axis_tuser_i == FUNC_TICK);
  assign sample_out = m_axis_tvalid_o && m_axis_tready_i;

  // Count of accepted ticks whose sample has not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 5'(tick_in) - 5'(sample_out);
    end
  end

  // A waiting sample is held until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("sample dropped or changed while stalled");

  // Every sample belongs to an earlier tick request.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> pend_q != 5'd0)
    else $error("sample without a pending tick");

  // The block never holds more ticks than its pipeline stages and output register.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= MaxInFlight)
    else $error("too many ticks in flight");

  // A free or draining output side never blocks new requests.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o || m_axis_tready_i |-> s_axis_tready_o)
    else $error("request side stalled without back pressure");

endmodule

bind mono_sawtooth_note_stack_osc_core mso_checker u_mso_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- bench/mso_sample_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the oscillator, keeps its own copy of the oscillator
// state, and compares every sample that leaves the block with the one predicted
// for the oldest outstanding tick request.
module mso_sample_checker
  import mso_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [STEP_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [1:0]            s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_count_o
);

  localparam int unsigned FRAC      = PHASE_FRAC_BITS_C;
  localparam int unsigned OCTAVE    = 49152;
  localparam int unsigned MAX_SHOWN = 10;

  // Predicted oscillator state.
  logic [STEP_W-1:0] base_step_q;
  logic [25:0]       phase_q;
  logic [STEP_W-1:0] step_q;
  logic [6:0]        gain_q;
  logic signed [13:0] bend_q;
  logic [6:0]        held_notes [STACK_DEPTH_C];
  logic [4:0]        depth_q;

  // One octave of 2^(i/N) in Q1.16.
  logic [16:0]       octave_tab [EXP_TABLE_SIZE_C];

  // Samples owed by accepted tick requests, oldest first.
  logic [15:0]       due_samples [$];

  logic [15:0]       want;
  logic [26:0]       next_phase;
  int unsigned       mism_n;
  int unsigned       pending_q;

  assign mismatch_count_o = mism_n;
  assign pending_count_o  = pending_q;

  // Exponent entry round(2^(i/N) * 2^16) by a power series of ln 2 in Q32.
  function automatic logic [16:0] octave_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned y;
    longint unsigned term;
    longint unsigned acc;
    x    = (longint'(i) << 32) / EXP_TABLE_SIZE_C;
    y    = (x * 64'd2977044472) >> 32;
    term = 64'd1 << 32;
    acc  = term;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * y) >> 32) / longint'(k);
      acc  = acc + term;
    end
    return 17'((acc + 64'd32768) >> 16);
  endfunction

  // Phase step for a pitch in 1/4096 semitone, saturated to the step width.
  function automatic logic [STEP_W-1:0] note_step(input int pitch,
                                                  input logic [STEP_W-1:0] base);
    int unsigned     q;
    int unsigned     oct;
    int unsigned     idx;
    longint unsigned v;
    q   = pitch + OCTAVE;
    oct = q / OCTAVE;
    idx = ((q % OCTAVE) * EXP_TABLE_SIZE_C) / OCTAVE;
    if (idx >= EXP_TABLE_SIZE_C) idx = EXP_TABLE_SIZE_C - 1;
    v = base;
    v = (v * octave_tab[idx]) << oct;
    v = v >> 17;
    if (v > 64'h1FFFFFF) return '1;
    return v[STEP_W-1:0];
  endfunction

  // Sawtooth value (2*frac(phase) - 1) * gain/127 in Q1.15, rounded down.
  function automatic logic [15:0] saw_sample(input logic [25:0] ph, input logic [6:0] g);
    longint s;
    longint num;
    longint den;
    longint res;
    s   = 2 * longint'(ph[FRAC-1:0]) - (longint'(1) << FRAC);
    num = s * longint'(g) * 32768;
    den = 127 * (longint'(1) << FRAC);
    if (num >= 0) res = num / den;
    else res = -((-num + den - 1) / den);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return res[15:0];
  endfunction

  // The step follows the top of the note stack, or is zero when it is empty.
  function automatic void refresh_step();
    if (depth_q == 0) step_q = '0;
    else step_q = note_step(int'(held_notes[depth_q - 1]) * 4096 + int'(bend_q), base_step_q);
  endfunction

  task automatic report_mismatch(input logic [15:0] expd, input logic [15:0] got,
                                 input bit orphan);
    mism_n++;
    if (mism_n <= MAX_SHOWN) begin
      if (orphan) $display("%0t: sample %0d arrived with no tick outstanding",
                           $realtime, $signed(got));
      else $display("%0t: sample mismatch, expected %0d, got %0d",
                    $realtime, $signed(expd), $signed(got));
    end
  endtask

  initial begin
    mism_n = 0;
    for (int i = 0; i < EXP_TABLE_SIZE_C; i++) octave_tab[i] = octave_entry(i);
  end

  // Compare outgoing samples first, then apply the request accepted at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_q = BASE_STEP_RST_C;
      phase_q     = '0;
      step_q      = '0;
      gain_q      = '0;
      bend_q      = '0;
      depth_q     = '0;
      due_samples.delete();
      pending_q  <= 0;
    end else begin
      if (cfg_we_i) base_step_q = cfg_wdata_i;

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_samples.size() == 0) begin
          report_mismatch('0, m_axis_tdata_i, 1'b1);
        end else begin
          want = due_samples.pop_front();
          if (want !== m_axis_tdata_i) report_mismatch(want, m_axis_tdata_i, 1'b0);
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        case (s_axis_tuser_i)
          FUNC_TICK: begin
            due_samples.push_back(saw_sample(phase_q, gain_q));
            next_phase = {1'b0, phase_q} + step_q;
            phase_q = (next_phase > (27'd1 << FRAC)) ? '0 : next_phase[25:0];
          end
          FUNC_NOTE_ON: begin
            // A full stack has its top replaced.
            if (depth_q >= STACK_DEPTH_C) begin
              held_notes[STACK_DEPTH_C - 1] = s_axis_tdata_i[6:0];
            end else begin
              held_notes[depth_q] = s_axis_tdata_i[6:0];
              depth_q = depth_q + 1;
            end
            gain_q = s_axis_tdata_i[13:7];
            refresh_step();
          end
          FUNC_NOTE_OFF: begin
            // A pop on an empty stack changes nothing.
            if (depth_q != 0) begin
              depth_q = depth_q - 1;
              refresh_step();
            end
          end
          default: begin
            bend_q = s_axis_tdata_i[27:14];
            if (depth_q != 0) refresh_step();
          end
        endcase
      end

      pending_q <= due_samples.size();
    end
  end

endmodule

// ----- bench/mono_sawtooth_note_stack_osc_core_tb.sv -----
`timescale 1ns / 1ps

module mono_sawtooth_note_stack_osc_core_tb;
  import mso_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LATENCY_PAD = 20;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [STEP_W-1:0]     cfg_wdata_i     = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]            s_axis_tuser_i  = FUNC_TICK;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  int unsigned mismatch_n;
  int unsigned pending_n;
  int unsigned sink_hold   = 0;
  int unsigned quiet_n     = 0;
  int unsigned sent_n      = 0;
  int unsigned stack_guess = 0;
  bit          steady      = 1'b0;

  always #5 clk_i = ~clk_i;

  mono_sawtooth_note_stack_osc_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  mso_sample_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid_i  (s_axis_tvalid_i),
    .s_axis_tready_i  (s_axis_tready_o),
    .s_axis_tdata_i   (s_axis_tdata_i),
    .s_axis_tuser_i   (s_axis_tuser_i),
    .m_axis_tvalid_i  (m_axis_tvalid_o),
    .m_axis_tready_i  (m_axis_tready_i),
    .m_axis_tdata_i   (m_axis_tdata_o),
    .mismatch_count_o (mismatch_n),
    .pending_count_o  (pending_n)
  );

  // Stall lengths are mostly short, with an occasional long one.
  function automatic int unsigned stall_len();
    if ($urandom_range(0, 99) < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned idle_len();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    return stall_len();
  endfunction

  // Seven-bit fields lean toward their extremes.
  function automatic logic [6:0] pick_7bit();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    return 7'($urandom);
  endfunction

  function automatic logic signed [13:0] pick_wheel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return -14'sd8192;
    if (r == 1) return 14'sd8191;
    return 14'($urandom);
  endfunction

  // Present one request, after a random idle gap, and wait until it is taken.
  task automatic send_request(input func_e f, input logic [6:0] note,
                              input logic [6:0] vel, input logic signed [13:0] wheel);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= f;
    s_axis_tdata_i  <= {4'd0, wheel, vel, note};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_n++;
    if (f == FUNC_NOTE_ON && stack_guess < STACK_DEPTH_C) stack_guess++;
    if (f == FUNC_NOTE_OFF && stack_guess != 0) stack_guess--;
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, pick_7bit(), pick_7bit(), pick_wheel());
  endtask

  // Hold requests back until every owed sample has left, then wait a little more.
  task automatic settle(input int unsigned tail);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_n != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_base_step(input logic [STEP_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random traffic built mostly from musical phrases, with some noise mixed in.
  task automatic run_mix(input int unsigned n);
    int unsigned start;
    int unsigned kind;
    int unsigned cnt;
    bit          paused;
    start  = sent_n;
    paused = 1'b0;
    while (sent_n - start < n) begin
      if (!paused && sent_n - start >= n / 2) begin
        settle(0);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_request(FUNC_NOTE_ON, pick_7bit(), pick_7bit(), pick_wheel());
        repeat ($urandom_range(1, 12)) send_tick();
        if ($urandom_range(0, 2) == 0) begin
          send_request(FUNC_WHEEL, pick_7bit(), pick_7bit(), pick_wheel());
          repeat ($urandom_range(1, 6)) send_tick();
        end
        if ($urandom_range(0, 9) < 6)
          send_request(FUNC_NOTE_OFF, pick_7bit(), pick_7bit(), pick_wheel());
      end else if (kind < 55) begin
        // Fill the stack, sometimes past full, then pop it down to empty and beyond.
        repeat ($urandom_range(1, 20)) begin
          send_request(FUNC_NOTE_ON, pick_7bit(), pick_7bit(), pick_wheel());
          repeat ($urandom_range(0, 2)) send_tick();
        end
        cnt = stack_guess + $urandom_range(0, 2);
        repeat (cnt) begin
          send_request(FUNC_NOTE_OFF, pick_7bit(), pick_7bit(), pick_wheel());
          repeat ($urandom_range(0, 2)) send_tick();
        end
      end else if (kind < 70) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(FUNC_WHEEL, pick_7bit(), pick_7bit(), pick_wheel());
          repeat ($urandom_range(1, 4)) send_tick();
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(5, 30)) send_tick();
      end else begin
        repeat ($urandom_range(1, 5))
          send_request(func_e'($urandom_range(0, 3)), pick_7bit(), pick_7bit(),
                       pick_wheel());
      end
    end
  endtask

  // The sample sink stalls in random runs of varying length.
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      m_axis_tready_i <= 1'b1;
      sink_hold       <= $urandom_range(0, 7);
    end else begin
      m_axis_tready_i <= 1'b0;
      sink_hold       <= stall_len();
    end
  end

  // Give up when neither stream has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_n <= 0;
      else
        quiet_n <= quiet_n + 1;
      if (quiet_n >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset base step: empty stack cases, bend extremes, gain extremes.
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd127, 7'd127, 14'sd0);
    send_request(FUNC_WHEEL, 7'd0, 7'd0, -14'sd8192);
    send_request(FUNC_NOTE_ON, 7'd0, 7'd127, 14'sd0);
    send_request(FUNC_TICK, 7'd127, 7'd127, 14'sd8191);
    send_request(FUNC_TICK, 7'd0, 7'd0, -14'sd1);
    send_request(FUNC_WHEEL, 7'd0, 7'd0, 14'sd8191);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_ON, 7'd127, 7'd1, 14'sd0);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_ON, 7'd64, 7'd0, 14'sd0);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd99, 7'd5, 14'sd0);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    settle(LATENCY_PAD);

    // Full-scale base step: a step of exactly one lands the phase on 1.0,
    // and the top note saturates the step.
    write_base_step(25'h1000000);
    send_request(FUNC_WHEEL, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_ON, 7'd0, 7'd127, 14'sd0);
    repeat (4) send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_ON, 7'd127, 7'd127, 14'sd0);
    repeat (2) send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_NOTE_OFF, 7'd0, 7'd0, 14'sd0);
    send_request(FUNC_TICK, 7'd0, 7'd0, 14'sd0);

    // Random phases, each under its own base step.
    for (int ph = 0; ph < 8; ph++) begin
      settle(LATENCY_PAD);
      case (ph)
        0: write_base_step(25'd0);
        1: write_base_step(BASE_STEP_RST_C);
        2: write_base_step(25'($urandom_range(1, 24'hFFFFFF)));
        3: write_base_step(25'h1000000);
        4: write_base_step(25'd1);
        5: write_base_step(25'h0AAAAAA);
        6: write_base_step(25'h0555555);
        default: write_base_step(25'($urandom_range(0, 25'h1000000)));
      endcase
      steady <= (ph == 3);
      run_mix(100);
    end

    settle(LATENCY_PAD);
    if (mismatch_n == 0 && pending_n == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
